### design/icmp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// icmp_pkg
// Shared types, constants and helpers of the ICMP echo request builder.
// ----------------------------------------------------------------------------
package icmp_pkg;

   localparam int unsigned PKT_WORDS       = 46;
   localparam int unsigned WORD_INDEX_BITS = 6;
   localparam int unsigned CSR_INDEX_BITS  = 3;
   localparam int unsigned CSR_DATA_BITS   = 64;

   typedef logic [WORD_INDEX_BITS-1:0] word_index_type;

   localparam word_index_type LAST_WORD_INDEX = word_index_type'(PKT_WORDS - 1);

   // Word positions within the packet.
   localparam word_index_type WORD_VER_IHL    = 6'd0;
   localparam word_index_type WORD_TOTAL_LEN  = 6'd1;
   localparam word_index_type WORD_FLAGS      = 6'd3;
   localparam word_index_type WORD_TTL_PROTO  = 6'd4;
   localparam word_index_type WORD_IP_CSUM    = 6'd5;
   localparam word_index_type WORD_SRC_HI     = 6'd6;
   localparam word_index_type WORD_SRC_LO     = 6'd7;
   localparam word_index_type WORD_DST_HI     = 6'd8;
   localparam word_index_type WORD_DST_LO     = 6'd9;
   localparam word_index_type WORD_ICMP_TYPE  = 6'd10;
   localparam word_index_type WORD_ICMP_CSUM  = 6'd11;
   localparam word_index_type WORD_ECHO_ID    = 6'd12;
   localparam word_index_type WORD_ECHO_SEQ   = 6'd13;
   localparam word_index_type WORD_TAG_0      = 6'd14;
   localparam word_index_type WORD_TAG_1      = 6'd15;
   localparam word_index_type WORD_TAG_2      = 6'd16;
   localparam word_index_type WORD_TAG_3      = 6'd17;
   localparam word_index_type WORD_TAG_4      = 6'd18;

   // Fixed header words.
   localparam logic [15:0] IP_VER_IHL_TOS = 16'h4500;
   localparam logic [15:0] IP_TOTAL_LEN   = 16'd92;
   localparam logic [15:0] IP_FLAGS_DF    = 16'h4000;
   localparam logic [7:0]  IP_PROTO_ICMP  = 8'd1;
   localparam logic [15:0] ICMP_ECHO_REQ  = 16'h0800;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_SOURCE_ADDRESS  = 3'd0,
      CSR_TIME_TO_LIVE    = 3'd1,
      CSR_ECHO_IDENTIFIER = 3'd2,
      CSR_PAYLOAD_HEAD    = 3'd3,
      CSR_PAYLOAD_TAIL    = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [31:0] source_address;
      logic [7:0]  time_to_live;
      logic [15:0] echo_identifier;
      logic [63:0] payload_head;
      logic [15:0] payload_tail;
   } cfg_type;

   // Fold the carries of a ones' complement sum of up to 16 words and invert.
   function automatic logic [15:0] csum_fold(input logic [19:0] acc);
      logic [16:0] s1;
      logic [15:0] s2;
      s1 = {1'b0, acc[15:0]} + {13'b0, acc[19:16]};
      s2 = s1[15:0] + {15'b0, s1[16]};
      return ~s2;
   endfunction

endpackage
`default_nettype wire

### design/icmp_csr.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// icmp_csr
// Configuration registers, written through a plain write port.
// ----------------------------------------------------------------------------
module icmp_csr (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               csr_we,
   input  wire [icmp_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire [icmp_pkg::CSR_DATA_BITS-1:0]  csr_wdata,
   output icmp_pkg::cfg_type                 cfg
);
   import icmp_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_SOURCE_ADDRESS:  cfg_in.source_address  = csr_wdata[31:0];
            CSR_TIME_TO_LIVE:    cfg_in.time_to_live    = csr_wdata[7:0];
            CSR_ECHO_IDENTIFIER: cfg_in.echo_identifier = csr_wdata[15:0];
            CSR_PAYLOAD_HEAD:    cfg_in.payload_head    = csr_wdata;
            CSR_PAYLOAD_TAIL:    cfg_in.payload_tail    = csr_wdata[15:0];
            default:             cfg_in = cfg_ff;    // drop writes beyond the map
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.source_address  <= 32'd0;
         cfg_ff.time_to_live    <= 8'd1;
         cfg_ff.echo_identifier <= 16'd0;
         cfg_ff.payload_head    <= 64'd0;
         cfg_ff.payload_tail    <= 16'd0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

### design/icmp_csum.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// icmp_csum
// IP header and ICMP checksums of one request.
// ----------------------------------------------------------------------------
module icmp_csum (
   input  wire icmp_pkg::cfg_type cfg,
   input  wire [31:0]             destination_address,
   input  wire [15:0]             sequence_number,
   output logic [15:0]            ip_csum,
   output logic [15:0]            icmp_csum
);
   import icmp_pkg::*;

   logic [19:0] ip_acc;
   logic [19:0] icmp_acc;

   // Checksum words count as zero; zero words are left out.
   assign ip_acc = {4'b0, IP_VER_IHL_TOS} + {4'b0, IP_TOTAL_LEN} + {4'b0, IP_FLAGS_DF}
                 + {4'b0, cfg.time_to_live, IP_PROTO_ICMP}
                 + {4'b0, cfg.source_address[31:16]} + {4'b0, cfg.source_address[15:0]}
                 + {4'b0, destination_address[31:16]} + {4'b0, destination_address[15:0]};

   assign icmp_acc = {4'b0, ICMP_ECHO_REQ} + {4'b0, cfg.echo_identifier}
                   + {4'b0, sequence_number}
                   + {4'b0, cfg.payload_head[63:48]} + {4'b0, cfg.payload_head[47:32]}
                   + {4'b0, cfg.payload_head[31:16]} + {4'b0, cfg.payload_head[15:0]}
                   + {4'b0, cfg.payload_tail};

   assign ip_csum   = csum_fold(ip_acc);
   assign icmp_csum = csum_fold(icmp_acc);

endmodule
`default_nettype wire

### design/icmp_word_mux.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// icmp_word_mux
// Selects the packet word at a given position.
// ----------------------------------------------------------------------------
module icmp_word_mux (
   input  wire icmp_pkg::cfg_type        cfg,
   input  wire [31:0]                    destination_address,
   input  wire [15:0]                    sequence_number,
   input  wire [15:0]                    ip_csum,
   input  wire [15:0]                    icmp_csum,
   input  wire icmp_pkg::word_index_type word_index,
   output logic [15:0]                   packet_word
);
   import icmp_pkg::*;

   always_comb begin
      case (word_index)
         WORD_VER_IHL:   packet_word = IP_VER_IHL_TOS;
         WORD_TOTAL_LEN: packet_word = IP_TOTAL_LEN;
         WORD_FLAGS:     packet_word = IP_FLAGS_DF;
         WORD_TTL_PROTO: packet_word = {cfg.time_to_live, IP_PROTO_ICMP};
         WORD_IP_CSUM:   packet_word = ip_csum;
         WORD_SRC_HI:    packet_word = cfg.source_address[31:16];
         WORD_SRC_LO:    packet_word = cfg.source_address[15:0];
         WORD_DST_HI:    packet_word = destination_address[31:16];
         WORD_DST_LO:    packet_word = destination_address[15:0];
         WORD_ICMP_TYPE: packet_word = ICMP_ECHO_REQ;
         WORD_ICMP_CSUM: packet_word = icmp_csum;
         WORD_ECHO_ID:   packet_word = cfg.echo_identifier;
         WORD_ECHO_SEQ:  packet_word = sequence_number;
         WORD_TAG_0:     packet_word = cfg.payload_head[63:48];
         WORD_TAG_1:     packet_word = cfg.payload_head[47:32];
         WORD_TAG_2:     packet_word = cfg.payload_head[31:16];
         WORD_TAG_3:     packet_word = cfg.payload_head[15:0];
         WORD_TAG_4:     packet_word = cfg.payload_tail;
         default:        packet_word = 16'h0000;   // IP id and zero fill
      endcase
   end

endmodule
`default_nettype wire

### design/icmp_echo_request_builder.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// icmp_echo_request_builder
// Builds a 92-byte IPv4 ICMP echo request from a destination and sequence.
// ----------------------------------------------------------------------------
// Each request item (destination address, sequence number) turns into one
// IPv4 packet of 46 big-endian 16-bit words, sent one word per cycle while
// rsp_tready is high, with tlast on word 45. The request register takes the
// item together with both checksums, computed as the item is accepted; the
// word counter then walks the packet into the output register. The next
// request is accepted in the same cycle that the last word of the current
// packet loads, so packets follow each other without gaps while the result
// side keeps tready high. Source address, TTL, echo identifier and payload
// tag come from the configuration registers, which must only be written
// while no packet is in flight.
// ----------------------------------------------------------------------------
module icmp_echo_request_builder (
   input  wire                                clock,
   input  wire                                reset,
   // request item
   input  wire                                req_tvalid,
   output logic                               req_tready,
   input  wire [47:0]                         req_tdata,  // [31:0] destination_address,
                                                          // [47:32] sequence_number
   // result item
   output logic                               rsp_tvalid,
   input  wire                                rsp_tready,
   output logic [23:0]                        rsp_tdata,  // [15:0] packet_word,
                                                          // [21:16] word_index, [23:22] zero
   output logic                               rsp_tlast,  // last_word
   // configuration
   input  wire                                csr_we,
   input  wire [icmp_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire [icmp_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);
   import icmp_pkg::*;

   cfg_type        cfg;

   // request register
   logic           cur_valid_ff, cur_valid_in;
   logic [31:0]    dst_ff;
   logic [15:0]    seq_ff;
   logic [15:0]    ip_csum_ff;
   logic [15:0]    icmp_csum_ff;
   word_index_type word_idx_ff, word_idx_in;

   // output register
   logic           rsp_valid_ff, rsp_valid_in;
   logic [15:0]    rsp_word_ff;
   word_index_type rsp_idx_ff;
   logic           rsp_last_ff;

   logic [15:0]    ip_csum_new;
   logic [15:0]    icmp_csum_new;
   logic [15:0]    word_sel;
   logic           out_load;
   logic           emit;
   logic           pkt_done;
   logic           req_accept;

   icmp_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // Checksums of the incoming item, stored with it.
   icmp_csum u_csum (
      .cfg                 (cfg),
      .destination_address (req_tdata[31:0]),
      .sequence_number     (req_tdata[47:32]),
      .ip_csum             (ip_csum_new),
      .icmp_csum           (icmp_csum_new)
   );

   icmp_word_mux u_word_mux (
      .cfg                 (cfg),
      .destination_address (dst_ff),
      .sequence_number     (seq_ff),
      .ip_csum             (ip_csum_ff),
      .icmp_csum           (icmp_csum_ff),
      .word_index          (word_idx_ff),
      .packet_word         (word_sel)
   );

   // The output register loads when empty or when its word is taken.
   assign out_load   = !rsp_valid_ff || rsp_tready;
   assign emit       = out_load && cur_valid_ff;
   assign pkt_done   = emit && (word_idx_ff == LAST_WORD_INDEX);
   // Take a new request when idle or as the last word leaves.
   assign req_tready = !cur_valid_ff || pkt_done;
   assign req_accept = req_tvalid && req_tready;

   always_comb begin
      cur_valid_in = cur_valid_ff;
      word_idx_in  = word_idx_ff;
      if (req_accept) begin
         cur_valid_in = 1'b1;
         word_idx_in  = '0;
      end else if (pkt_done) begin
         cur_valid_in = 1'b0;
         word_idx_in  = '0;
      end else if (emit) begin
         word_idx_in  = word_idx_ff + word_index_type'(1);
      end
   end

   assign rsp_valid_in = out_load ? cur_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         word_idx_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         word_idx_ff  <= word_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload: hold the request fields for the whole packet.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         dst_ff       <= req_tdata[31:0];
         seq_ff       <= req_tdata[47:32];
         ip_csum_ff   <= ip_csum_new;
         icmp_csum_ff <= icmp_csum_new;
      end
   end

   // Payload: advance the output word whenever the register can load.
   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_word_ff <= word_sel;
         rsp_idx_ff  <= word_idx_ff;
         rsp_last_ff <= (word_idx_ff == LAST_WORD_INDEX);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_idx_ff, rsp_word_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule
`default_nettype wire

### tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the ICMP echo request builder.
// ----------------------------------------------------------------------------
// Sends echo request items (destination, sequence) and rebuilds each expected
// 46-word IPv4 packet, both checksums included, from a local copy of the
// configuration. Every accepted output word is compared with the oldest
// expected word. The request side runs in bursts with random gaps, and the
// result side stalls in changing patterns. Register settings change only
// while the block is idle and include the all-zero and all-one extremes.
// ----------------------------------------------------------------------------
module tb;
   import icmp_pkg::*;

   localparam int unsigned CSR_MAPPED      = 5;    // registers that exist
   localparam int unsigned CSR_SLOTS       = 1 << CSR_INDEX_BITS;
   localparam int unsigned SETTLE_CYCLES   = 8;    // quiet time after the last word
   localparam int unsigned RANDOM_PHASES   = 8;
   localparam int unsigned ITEMS_PER_PHASE = 20;
   localparam int unsigned REPORT_LIMIT    = 20;   // mismatches printed in full

   typedef struct {
      logic [15:0]    packet_word;
      word_index_type word_index;
      logic           last_word;
   } echo_word_type;

   // -------------------------------------------------------------------------
   // Packet predictor and store of expected words
   // -------------------------------------------------------------------------
   class echo_packet_board;
      cfg_type       regs;
      logic [15:0]   frame [PKT_WORDS];
      echo_word_type pending_words [$];
      int unsigned   requests_seen;
      int unsigned   words_checked;
      int unsigned   mismatches;

      function new();
         regs = '0;
         regs.time_to_live = 8'd1;
         requests_seen = 0;
         words_checked = 0;
         mismatches = 0;
      endfunction

      // Mirror one register write; unmapped indexes and excess bits drop.
      function void apply_register(logic [CSR_INDEX_BITS-1:0] index, logic [63:0] value);
         case (index)
            CSR_SOURCE_ADDRESS:  regs.source_address  = value[31:0];
            CSR_TIME_TO_LIVE:    regs.time_to_live    = value[7:0];
            CSR_ECHO_IDENTIFIER: regs.echo_identifier = value[15:0];
            CSR_PAYLOAD_HEAD:    regs.payload_head    = value;
            CSR_PAYLOAD_TAIL:    regs.payload_tail    = value[15:0];
            default: ;
         endcase
      endfunction

      // Ones' complement sum over a span of the frame, folded and inverted.
      function logic [15:0] checksum_over(int first, int count);
         logic [31:0] acc;
         acc = '0;
         for (int k = 0; k < count; k++)
            acc += {16'h0, frame[first + k]};
         acc = (acc >> 16) + (acc & 32'h0000_ffff);
         acc += acc >> 16;
         return ~acc[15:0];
      endfunction

      function void build_frame(logic [31:0] destination, logic [15:0] sequence_number);
         foreach (frame[k])
            frame[k] = '0;
         frame[WORD_VER_IHL]   = IP_VER_IHL_TOS;
         frame[WORD_TOTAL_LEN] = IP_TOTAL_LEN;
         frame[WORD_FLAGS]     = IP_FLAGS_DF;
         frame[WORD_TTL_PROTO] = {regs.time_to_live, IP_PROTO_ICMP};
         frame[WORD_SRC_HI]    = regs.source_address[31:16];
         frame[WORD_SRC_LO]    = regs.source_address[15:0];
         frame[WORD_DST_HI]    = destination[31:16];
         frame[WORD_DST_LO]    = destination[15:0];
         frame[WORD_IP_CSUM]   = checksum_over(WORD_VER_IHL, WORD_ICMP_TYPE);
         frame[WORD_ICMP_TYPE] = ICMP_ECHO_REQ;
         frame[WORD_ECHO_ID]   = regs.echo_identifier;
         frame[WORD_ECHO_SEQ]  = sequence_number;
         frame[WORD_TAG_0]     = regs.payload_head[63:48];
         frame[WORD_TAG_1]     = regs.payload_head[47:32];
         frame[WORD_TAG_2]     = regs.payload_head[31:16];
         frame[WORD_TAG_3]     = regs.payload_head[15:0];
         frame[WORD_TAG_4]     = regs.payload_tail;
         frame[WORD_ICMP_CSUM] = checksum_over(WORD_ICMP_TYPE, PKT_WORDS - WORD_ICMP_TYPE);
      endfunction

      function void note_request(logic [31:0] destination, logic [15:0] sequence_number);
         echo_word_type expected_word;
         build_frame(destination, sequence_number);
         for (int k = 0; k < PKT_WORDS; k++) begin
            expected_word.packet_word = frame[k];
            expected_word.word_index  = word_index_type'(k);
            expected_word.last_word   = (k == PKT_WORDS - 1);
            pending_words.push_back(expected_word);
         end
         requests_seen++;
      endfunction

      function void flag_field(string field, logic [15:0] expected, logic [15:0] actual);
         if (expected !== actual) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $error("%s mismatch: expected %h, actual %h", field, expected, actual);
         end
      endfunction

      function void check_word(logic [15:0] packet_word, word_index_type word_index,
                               logic last_word);
         echo_word_type expected_word;
         words_checked++;
         if (pending_words.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $error("packet_word %h at word_index %0d arrived with nothing expected",
                      packet_word, word_index);
            return;
         end
         expected_word = pending_words.pop_front();
         flag_field("packet_word", expected_word.packet_word, packet_word);
         flag_field("word_index", 16'(expected_word.word_index), 16'(word_index));
         flag_field("last_word", 16'(expected_word.last_word), 16'(last_word));
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Clock, reset and block
   // -------------------------------------------------------------------------
   logic                      clock;
   logic                      reset      = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [47:0]               req_tdata  = '0;  // [31:0] destination_address,
                                                // [47:32] sequence_number
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [23:0]               rsp_tdata;        // [15:0] packet_word,
                                                // [21:16] word_index, [23:22] zero
   logic                      rsp_tlast;
   logic                      csr_we     = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index  = '0;
   logic [CSR_DATA_BITS-1:0]  csr_wdata  = '0;

   echo_packet_board board;
   int unsigned      burst_left     = 0;  // items left in the current request burst
   int unsigned      idle_gap       = 0;  // cycles to hold off before the next item
   int unsigned      settings_count = 0;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   icmp_echo_request_builder dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // -------------------------------------------------------------------------
   // Request side
   // -------------------------------------------------------------------------
   // Offer one request item and hold it until accepted. Valid stays high
   // across a burst; when a burst ends, either drop valid for a random gap
   // or roll straight into the next burst without lowering it.
   task automatic send_request(input logic [31:0] destination,
                               input logic [15:0] sequence_number);
      if (idle_gap != 0) begin
         repeat (idle_gap) @(posedge clock);
         idle_gap = 0;
      end
      if (burst_left == 0)
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40)
                                                   : $urandom_range(1, 6);
      req_tvalid <= 1'b1;
      req_tdata  <= {sequence_number, destination};
      do @(posedge clock); while (!req_tready);
      board.note_request(destination, sequence_number);
      burst_left--;
      if (burst_left == 0) begin
         idle_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
         if (idle_gap != 0)
            req_tvalid <= 1'b0;
      end
   endtask

   // Close the request stream at the end of a phase. Valid is still high
   // exactly when no gap was scheduled after the last item.
   task automatic close_requests();
      if (idle_gap == 0)
         req_tvalid <= 1'b0;
      idle_gap   = 0;
      burst_left = 0;
   endtask

   // Wait until every expected word is out, then let the block settle.
   task automatic drain_packets();
      while (board.pending_words.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // -------------------------------------------------------------------------
   // Configuration side
   // -------------------------------------------------------------------------
   // Write one register; the write enable stays high for back-to-back writes.
   task automatic write_register(input logic [CSR_INDEX_BITS-1:0] index,
                                 input logic [CSR_DATA_BITS-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      board.apply_register(index, value);
   endtask

   // Load a full register setting, then poke the unmapped indexes with junk,
   // which the block must ignore. Callers pass full 64-bit words so that the
   // bits above each register's width get exercised too.
   task automatic program_registers(input logic [63:0] source_value,
                                    input logic [63:0] ttl_value,
                                    input logic [63:0] identifier_value,
                                    input logic [63:0] head_value,
                                    input logic [63:0] tail_value);
      write_register(CSR_SOURCE_ADDRESS, source_value);
      write_register(CSR_TIME_TO_LIVE, ttl_value);
      write_register(CSR_ECHO_IDENTIFIER, identifier_value);
      write_register(CSR_PAYLOAD_HEAD, head_value);
      write_register(CSR_PAYLOAD_TAIL, tail_value);
      for (int slot = CSR_MAPPED; slot < CSR_SLOTS; slot++)
         write_register(slot[CSR_INDEX_BITS-1:0], {$urandom, $urandom});
      csr_we <= 1'b0;
      settings_count++;
   endtask

   function automatic logic [63:0] pick_register_value();
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // Checksum edge: pick the destination low word (then the sequence number)
   // so that the covered words sum to all ones and the checksum comes out 0.
   // Building the frame with that word at zero yields exactly that value.
   task automatic send_zero_checksums();
      logic [31:0] destination;
      logic [15:0] fill_word;
      destination = $urandom;
      board.build_frame({destination[31:16], 16'h0000}, 16'(($urandom)));
      fill_word = board.frame[WORD_IP_CSUM];
      send_request({destination[31:16], fill_word}, 16'($urandom));
      board.build_frame(destination, 16'h0000);
      fill_word = board.frame[WORD_ICMP_CSUM];
      send_request(destination, fill_word);
   endtask

   // -------------------------------------------------------------------------
   // Result side: stall pattern and checker
   // -------------------------------------------------------------------------
   // Switch among always ready, sparse stalls, a periodic stall and heavy
   // backpressure, each for a random stretch.
   initial begin
      int unsigned mode;
      int unsigned span;
      int unsigned period;
      int unsigned tick;
      tick = 0;
      forever begin
         mode   = $urandom_range(0, 3);
         span   = $urandom_range(20, 200);
         period = $urandom_range(2, 7);
         repeat (span) begin
            @(posedge clock);
            tick++;
            case (mode)
               0:       rsp_tready <= 1'b1;
               1:       rsp_tready <= ($urandom_range(0, 3) != 0);
               2:       rsp_tready <= (tick % period != 0);
               default: rsp_tready <= ($urandom_range(0, 4) == 0);
            endcase
         end
      end
   end

   // Check each word accepted at this edge.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         board.check_word(rsp_tdata[15:0], rsp_tdata[21:16], rsp_tlast);
   end

   // -------------------------------------------------------------------------
   // Stimulus
   // -------------------------------------------------------------------------
   initial begin
      logic [31:0] destination;
      logic [15:0] sequence_base;
      board = new();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Register reset values: TTL 1, everything else zero.
      send_request(32'h0000_0000, 16'h0000);
      send_request(32'hffff_ffff, 16'hffff);
      send_request(32'hc0a8_0001, 16'h0001);
      close_requests();
      drain_packets();

      // Every register at its maximum, written with all 64 bits set.
      program_registers('1, '1, '1, '1, '1);
      send_request(32'h0000_0000, 16'h0000);
      send_request(32'hffff_ffff, 16'hffff);
      send_zero_checksums();
      close_requests();
      drain_packets();

      // Every register at zero, TTL 0 included.
      program_registers('0, '0, '0, '0, '0);
      send_request(32'h0000_0000, 16'h0000);
      send_request(32'hffff_ffff, 16'hffff);
      send_zero_checksums();
      close_requests();
      drain_packets();

      // Random settings, each followed by a run of random requests. Half the
      // sequence numbers count up as a pinging host would send them.
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         program_registers(pick_register_value(), pick_register_value(),
                           pick_register_value(), pick_register_value(),
                           pick_register_value());
         sequence_base = 16'($urandom);
         for (int item = 0; item < ITEMS_PER_PHASE; item++) begin
            case ($urandom_range(0, 9))
               0:       destination = '0;
               1:       destination = '1;
               default: destination = $urandom;
            endcase
            send_request(destination,
                         ($urandom_range(0, 1) == 0) ? 16'(sequence_base + item)
                                                     : 16'($urandom));
         end
         close_requests();
         drain_packets();
      end

      $display("Covered %0d echo requests under %0d register settings, %0d words checked,",
               board.requests_seen, settings_count, board.words_checked);
      $display("with bursty requests, changing output stalls and checksum edge cases.");
      if (board.mismatches == 0 && board.pending_words.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   // Hard stop far beyond the slowest legal run.
   initial begin
      #6_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

### filelist.f
design/icmp_pkg.sv
design/icmp_csr.sv
design/icmp_csum.sv
design/icmp_word_mux.sv
design/icmp_echo_request_builder.sv
tb/tb.sv
